// ----- design/mbrf_pkg.sv -----
`default_nettype none

package mbrf_pkg;

  // Frame geometry
  localparam int unsigned FrameLen = 8;
  localparam int unsigned BodyLen  = 6;
  localparam int unsigned IdxW     = $clog2(FrameLen);

  // Defaults
  localparam int unsigned DefQueueDepth = 2;
  localparam logic [7:0]  DevAddrReset  = 8'h01;

  // CRC-16/Modbus
  localparam logic [15:0] CrcSeed = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // Function codes
  localparam logic [7:0] FcReadHolding = 8'h03;
  localparam logic [7:0] FcReadInput   = 8'h04;
  localparam logic [7:0] FcWriteSingle = 8'h06;

  // Byte positions in the frame
  localparam logic [IdxW-1:0] PosDev    = IdxW'(0);
  localparam logic [IdxW-1:0] PosFc     = IdxW'(1);
  localparam logic [IdxW-1:0] PosAddrHi = IdxW'(2);
  localparam logic [IdxW-1:0] PosAddrLo = IdxW'(3);
  localparam logic [IdxW-1:0] PosDataHi = IdxW'(4);
  localparam logic [IdxW-1:0] PosDataLo = IdxW'(5);
  localparam logic [IdxW-1:0] PosCrcLo  = IdxW'(6);
  localparam logic [IdxW-1:0] PosCrcHi  = IdxW'(7);

  typedef enum logic [1:0] {
    ActReadHolding = 2'd0,
    ActReadInput   = 2'd1,
    ActWriteSingle = 2'd2
  } action_e;

  // One classified request waiting for the back end
  typedef struct packed {
    logic [7:0]  dev;
    logic [7:0]  fc;
    logic [15:0] addr;
    logic [15:0] data;
  } mbrf_entry_t;

  // Fold one byte into the running CRC, bit by bit
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) c = (c >> 1) ^ CrcPoly;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- design/mbrf_front.sv -----
`default_nettype none

module mbrf_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [7:0]         cfg_wdata_i,
  input  wire logic               start_i,
  input  wire logic               full_i,
  input  wire logic [1:0]         action_i,
  input  wire logic [15:0]        register_address_i,
  input  wire logic [15:0]        payload_i,
  output logic                    busy_o,
  output logic                    push_o,
  output mbrf_pkg::mbrf_entry_t   entry_o
);
  import mbrf_pkg::*;

  logic [7:0] dev_q, dev_d;
  logic       act_ok;

  // Slave address register
  always_comb begin
    dev_d = dev_q;
    if (cfg_we_i) dev_d = cfg_wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q <= DevAddrReset;
    end else begin
      dev_q <= dev_d;
    end
  end

  // Classify the request; unknown actions are dropped
  always_comb begin
    act_ok        = 1'b1;
    entry_o.dev   = dev_q;
    entry_o.addr  = register_address_i;
    entry_o.fc    = FcReadHolding;
    entry_o.data  = {8'h00, payload_i[7:0]};
    unique case (action_i)
      ActReadHolding: entry_o.fc = FcReadHolding;
      ActReadInput:   entry_o.fc = FcReadInput;
      ActWriteSingle: begin
        entry_o.fc   = FcWriteSingle;
        entry_o.data = payload_i;
      end
      default:        act_ok = 1'b0;
    endcase
  end

  assign busy_o = full_i;
  assign push_o = start_i && !full_i && act_ok;

endmodule

`default_nettype wire

// ----- design/mbrf_queue.sv -----
`default_nettype none

module mbrf_queue #(
  parameter int unsigned Depth = mbrf_pkg::DefQueueDepth
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    push_i,
  input  wire mbrf_pkg::mbrf_entry_t   entry_i,
  input  wire logic                    pop_i,
  output mbrf_pkg::mbrf_entry_t        head_o,
  output logic                         empty_o,
  output logic                         full_o
);
  import mbrf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mbrf_entry_t         mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign empty_o = (cnt_q == CntW'(0));
  assign full_o  = (cnt_q == CntW'(Depth));
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? PtrW'(0) : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? PtrW'(0) : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) cnt_d = cnt_q + CntW'(1);
    else if (!do_push && do_pop) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= entry_i;
  end

endmodule

`default_nettype wire

// ----- design/mbrf_back.sv -----
`default_nettype none

module mbrf_back (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire mbrf_pkg::mbrf_entry_t   head_i,
  input  wire logic                    empty_i,
  output logic                         pop_o,
  output logic [7:0]                   frame_byte_o,
  output logic                         last_byte_o,
  output logic                         byte_valid_o
);
  import mbrf_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StSend = 1'b1;

  logic              state_q, state_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  mbrf_entry_t       cur_q, cur_d;
  logic [15:0]       crc_q, crc_d;
  logic [7:0]        byte_d, byte_q;
  logic              valid_d, valid_q, last_d, last_q;
  logic [7:0]        cur_byte;
  logic [15:0]       crc_in;
  logic              frame_done;

  // Byte for the current position
  always_comb begin
    unique case (idx_q)
      PosDev:    cur_byte = cur_q.dev;
      PosFc:     cur_byte = cur_q.fc;
      PosAddrHi: cur_byte = cur_q.addr[15:8];
      PosAddrLo: cur_byte = cur_q.addr[7:0];
      PosDataHi: cur_byte = cur_q.data[15:8];
      PosDataLo: cur_byte = cur_q.data[7:0];
      PosCrcLo:  cur_byte = crc_q[7:0];
      PosCrcHi:  cur_byte = crc_q[15:8];
      default:   cur_byte = 8'h00;
    endcase
  end

  assign crc_in     = (idx_q == PosDev) ? CrcSeed : crc_q;
  assign frame_done = (state_q == StSend) && (idx_q == PosCrcHi);
  assign pop_o      = ((state_q == StIdle) || frame_done) && !empty_i;

  // Sequencer: one frame byte per cycle, next entry taken on the last byte
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cur_d   = cur_q;
    crc_d   = crc_q;
    byte_d  = cur_byte;
    valid_d = 1'b0;
    last_d  = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (!empty_i) begin
          state_d = StSend;
          idx_d   = PosDev;
          cur_d   = head_i;
        end
      end
      StSend: begin
        valid_d = 1'b1;
        last_d  = frame_done;
        if (idx_q < PosCrcLo) crc_d = crc_byte(crc_in, cur_byte);
        if (frame_done) begin
          idx_d = PosDev;
          if (empty_i) begin
            state_d = StIdle;
          end else begin
            cur_d = head_i;
          end
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q   <= '0;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      valid_q <= valid_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    crc_q  <= crc_d;
    byte_q <= byte_d;
  end

  assign frame_byte_o = byte_q;
  assign last_byte_o  = last_q;
  assign byte_valid_o = valid_q;

endmodule

`default_nettype wire

// ----- design/modbus_rtu_request_framer_core.sv -----
// Channel   | Ports                                          | Handshake
// ----------+------------------------------------------------+---------------------------
// request   | action_i, register_address_i, payload_i        | start_i && !busy_o
// frame     | frame_byte_o, last_byte_o                      | byte_valid_o, one cycle
// config    | cfg_wdata_i (slave address)                    | cfg_we_i
//
// A request yields eight frame bytes, one per cycle; the queue, the sequencer state and
// the output registers lie between acceptance and the first byte. The byte sequencer sets
// the rate, with a two-entry queue in front so a new request is taken while a frame goes out.
// The CRC is folded in one byte per cycle as the body bytes leave.
// Reset clears the queue and sequencer and sets the slave address to 1.
// The receiver cannot stall; busy_o is high only while the queue is full.
`default_nettype none

module modbus_rtu_request_framer_core #(
  parameter int unsigned QueueDepth = mbrf_pkg::DefQueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [15:0] register_address_i,
  input  wire logic [15:0] payload_i,
  output logic             byte_valid_o,
  output logic [7:0]       frame_byte_o,
  output logic             last_byte_o
);
  import mbrf_pkg::*;

  mbrf_entry_t push_entry, head_entry;
  logic        push, pop, empty, full;

  mbrf_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .start_i            (start_i),
    .full_i             (full),
    .action_i           (action_i),
    .register_address_i (register_address_i),
    .payload_i          (payload_i),
    .busy_o             (busy_o),
    .push_o             (push),
    .entry_o            (push_entry)
  );

  mbrf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head_entry),
    .empty_o (empty),
    .full_o  (full)
  );

  mbrf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_entry),
    .empty_i      (empty),
    .pop_o        (pop),
    .frame_byte_o (frame_byte_o),
    .last_byte_o  (last_byte_o),
    .byte_valid_o (byte_valid_o)
  );

endmodule

`default_nettype wire

// ----- design/mbrf_checker.sv -----
`default_nettype none

module mbrf_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic byte_valid_o,
  input wire logic last_byte_o
);

  // Last flag only rides on a valid byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_byte_o |-> byte_valid_o)
    else $error("last_byte without byte_valid");

  // Bytes of one frame come out without gaps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_valid_o && !last_byte_o) |=> byte_valid_o)
    else $error("gap inside a frame");

  // Two last flags never in a row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_byte_o |=> !last_byte_o)
    else $error("back-to-back last bytes");

  // A frame is eight bytes long
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_byte_o |-> ($past(byte_valid_o, 7) && !$past(last_byte_o, 1)))
    else $error("short frame");

endmodule

bind modbus_rtu_request_framer_core mbrf_checker u_mbrf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .byte_valid_o (byte_valid_o),
  .last_byte_o  (last_byte_o)
);

`default_nettype wire
